@@ hw/rtl/rfa_pkg.sv @@
`default_nettype none

package rfa_pkg;

  localparam int unsigned BUF_DEPTH = 32;
  localparam int unsigned BUF_AW    = 5;

  localparam logic [2:0] KIND_UDEC = 3'd0;
  localparam logic [2:0] KIND_SDEC = 3'd1;
  localparam logic [2:0] KIND_HEX  = 3'd2;
  localparam logic [2:0] KIND_OCT  = 3'd3;
  localparam logic [2:0] KIND_BIN  = 3'd4;

  localparam logic [7:0] ASCII_ZERO  = 8'd48;
  localparam logic [7:0] ASCII_MINUS = 8'd45;
  localparam logic [7:0] ASCII_A     = 8'd65;

  typedef enum logic [1:0] {
    RADIX_DEC,
    RADIX_HEX,
    RADIX_OCT,
    RADIX_BIN
  } radix_e;

  typedef struct packed {
    logic              we;
    logic [BUF_AW-1:0] addr;
    logic [7:0]        data;
  } ram_wr_t;

  typedef struct packed {
    logic              done;
    logic [BUF_AW-1:0] top;
  } conv_res_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    if (d > 4'd9) begin
      c = ASCII_A + {4'd0, d} - 8'd10;
    end else begin
      c = ASCII_ZERO + {4'd0, d};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/rfa_ram.sv @@
`default_nettype none

module rfa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ hw/rtl/rfa_conv.sv @@
`default_nettype none

module rfa_conv
  import rfa_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  radix_e                 radix_i,
  input  logic [VALUE_WIDTH-1:0] mag_i,
  input  logic [BUF_AW-1:0]      bin_last_i,
  output ram_wr_t                wr_o,
  output conv_res_t              res_o
);

  localparam int unsigned NDEC = (VALUE_WIDTH * 1233) / 4096 + 1;
  localparam int unsigned BCDW = 4 * NDEC;
  localparam int unsigned SRW  = (BCDW > 32) ? BCDW : 32;
  localparam int unsigned NHEX = (VALUE_WIDTH + 3) / 4;
  localparam int unsigned NOCT = (VALUE_WIDTH + 2) / 3;
  localparam int unsigned CW   = $clog2(VALUE_WIDTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DABBLE,
    S_STORE
  } state_e;

  state_e              state_q, state_d;
  radix_e              radix_q, radix_d;
  logic [SRW-1:0]      sr_q, sr_d;
  logic [VALUE_WIDTH-1:0] bin_q, bin_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [BUF_AW-1:0]   k_q, k_d;
  logic [BUF_AW-1:0]   hi_q, hi_d;
  logic [BUF_AW-1:0]   last_q, last_d;
  conv_res_t           res_q, res_d;
  logic [3:0]          dig;
  logic [BCDW-1:0]     bcd_adj;

  function automatic logic [BCDW-1:0] dabble_adj(input logic [BCDW-1:0] b);
    logic [BCDW-1:0] r;
    r = b;
    for (int i = 0; i < NDEC; i++) begin
      if (b[4*i +: 4] >= 4'd5) begin
        r[4*i +: 4] = b[4*i +: 4] + 4'd3;
      end
    end
    return r;
  endfunction

  always_comb begin
    unique case (radix_q)
      RADIX_OCT: dig = {1'b0, sr_q[2:0]};
      RADIX_BIN: dig = {3'd0, sr_q[0]};
      default:   dig = sr_q[3:0];
    endcase
  end

  assign bcd_adj = dabble_adj(sr_q[BCDW-1:0]);

  always_comb begin
    state_d = state_q;
    radix_d = radix_q;
    sr_d    = sr_q;
    bin_d   = bin_q;
    cnt_d   = cnt_q;
    k_d     = k_q;
    hi_d    = hi_q;
    last_d  = last_q;
    res_d   = '{done: 1'b0, top: res_q.top};
    wr_o    = '{we: 1'b0, addr: k_q, data: digit_char(dig)};
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          radix_d = radix_i;
          k_d     = '0;
          hi_d    = '0;
          cnt_d   = '0;
          unique case (radix_i)
            RADIX_DEC: begin
              sr_d    = '0;
              bin_d   = mag_i;
              last_d  = BUF_AW'(NDEC - 1);
              state_d = S_DABBLE;
            end
            RADIX_HEX: begin
              sr_d    = SRW'(mag_i);
              last_d  = BUF_AW'(NHEX - 1);
              state_d = S_STORE;
            end
            RADIX_OCT: begin
              sr_d    = SRW'(mag_i);
              last_d  = BUF_AW'(NOCT - 1);
              state_d = S_STORE;
            end
            RADIX_BIN: begin
              sr_d    = SRW'(mag_i);
              last_d  = bin_last_i;
              state_d = S_STORE;
            end
          endcase
        end
      end
      S_DABBLE: begin
        sr_d  = SRW'({bcd_adj[BCDW-2:0], bin_q[VALUE_WIDTH-1]});
        bin_d = bin_q << 1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CW'(VALUE_WIDTH - 1)) begin
          state_d = S_STORE;
        end
      end
      S_STORE: begin
        wr_o.we = 1'b1;
        if (dig != 4'd0) begin
          hi_d = k_q;
        end
        unique case (radix_q)
          RADIX_OCT: sr_d = sr_q >> 3;
          RADIX_BIN: sr_d = sr_q >> 1;
          default:   sr_d = sr_q >> 4;
        endcase
        k_d = k_q + 1'b1;
        if (k_q == last_q) begin
          res_d.done = 1'b1;
          if (radix_q == RADIX_BIN) begin
            res_d.top = last_q;
          end else if (dig != 4'd0) begin
            res_d.top = k_q;
          end else begin
            res_d.top = hi_q;
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      res_q   <= '0;
      k_q     <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
      k_q     <= k_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    radix_q <= radix_d;
    sr_q    <= sr_d;
    bin_q   <= bin_d;
    hi_q    <= hi_d;
    last_q  <= last_d;
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

@@ hw/rtl/radix_ascii_formatter.sv @@
// Radix ASCII formatter.
// Input item (s_axis): tuser carries the format kind (0 unsigned decimal, 1 signed
// decimal, 2 hex, 3 octal, 4 binary; 5..7 act as unsigned decimal), tdata carries
// the value and the binary digit count. Output (m_axis): one ASCII character per
// item, most significant first, tlast on the final character of the text.
// One value is handled at a time; s_axis_tready_o is high only while idle.
// Steps: the accept, VALUE_WIDTH double-dabble shift steps for decimal kinds, the
// digit writes to the digit RAM (decimal digits of VALUE_WIDTH bits, hex or octal
// digits of VALUE_WIDTH bits, or the binary count), and a hand-over to the output
// side. Each digit then takes a RAM read and the output register load, as a read
// is issued only after the previous one has landed; a minus sign needs no read.
// Reset clears the state machines, counters, flags and output register; the
// digit RAM is not cleared, as every entry is written before it is read. When
// the receiver stalls, the character in the output register holds and no
// further reads are issued; after the last character is loaded the block is
// idle again and takes the next value while that character still waits.
`default_nettype none

module radix_ascii_formatter
  import rfa_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,  // value[31:0], bin_digits[37:32], zero pad
  input  logic [2:0]  s_axis_tuser_i,  // kind[2:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,  // char_code[7:0]
  output logic        m_axis_tlast_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_EMIT
  } state_e;

  state_e            state_q, state_d;
  logic              neg_q, neg_d;
  logic              pend_q, pend_d;
  logic              pend_last_q, pend_last_d;
  logic [BUF_AW-1:0] idx_q, idx_d;
  logic              m_valid_q, m_valid_d;
  logic [7:0]        m_data_q, m_data_d;
  logic              m_last_q, m_last_d;

  logic                   accept;
  logic [VALUE_WIDTH-1:0] v;
  logic [VALUE_WIDTH-1:0] mag;
  logic                   neg;
  radix_e                 radix;
  logic [5:0]             nb;
  logic [BUF_AW-1:0]      bin_last;
  logic                   slot_free;
  logic [BUF_AW-1:0]      raddr;
  logic [7:0]             rdata;
  ram_wr_t                ram_wr;
  conv_res_t              conv_res;

  assign accept = s_axis_tvalid_i && s_axis_tready_o;
  assign v      = VALUE_WIDTH'(s_axis_tdata_i[31:0]);
  assign nb     = s_axis_tdata_i[37:32];

  always_comb begin
    unique case (s_axis_tuser_i)
      KIND_HEX: radix = RADIX_HEX;
      KIND_OCT: radix = RADIX_OCT;
      KIND_BIN: radix = RADIX_BIN;
      default:  radix = RADIX_DEC;
    endcase
  end

  assign neg = (s_axis_tuser_i == KIND_SDEC) && v[VALUE_WIDTH-1];
  assign mag = neg ? VALUE_WIDTH'(~v + 1'b1) : v;

  always_comb begin
    priority if (nb == 6'd0) begin
      bin_last = '0;
    end else if (nb > 6'(BUF_DEPTH)) begin
      bin_last = BUF_AW'(BUF_DEPTH - 1);
    end else begin
      bin_last = BUF_AW'(nb - 6'd1);
    end
  end

  rfa_conv #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_conv (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (accept),
    .radix_i   (radix),
    .mag_i     (mag),
    .bin_last_i(bin_last),
    .wr_o      (ram_wr),
    .res_o     (conv_res)
  );

  rfa_ram #(
    .WIDTH(8),
    .DEPTH(BUF_DEPTH)
  ) u_digit_ram (
    .clk_i  (clk_i),
    .we_i   (ram_wr.we),
    .waddr_i(ram_wr.addr),
    .wdata_i(ram_wr.data),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign slot_free = !m_valid_q || m_axis_tready_i;
  assign raddr     = idx_q;

  always_comb begin
    state_d     = state_q;
    neg_d       = neg_q;
    pend_d      = pend_q;
    pend_last_d = pend_last_q;
    idx_d       = idx_q;
    m_valid_d   = m_valid_q && !m_axis_tready_i;
    m_data_d    = m_data_q;
    m_last_d    = m_last_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          neg_d   = neg;
          state_d = S_CONV;
        end
      end
      S_CONV: begin
        if (conv_res.done) begin
          idx_d   = conv_res.top;
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (pend_q) begin
          m_valid_d = 1'b1;
          m_data_d  = rdata;
          m_last_d  = pend_last_q;
          pend_d    = 1'b0;
          if (pend_last_q) begin
            state_d = S_IDLE;
          end
        end else if (slot_free) begin
          if (neg_q) begin
            m_valid_d = 1'b1;
            m_data_d  = ASCII_MINUS;
            m_last_d  = 1'b0;
            neg_d     = 1'b0;
          end else begin
            pend_d      = 1'b1;
            pend_last_d = (idx_q == '0);
            idx_d       = idx_q - 1'b1;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      neg_q       <= 1'b0;
      pend_q      <= 1'b0;
      pend_last_q <= 1'b0;
      idx_q       <= '0;
      m_valid_q   <= 1'b0;
      m_data_q    <= '0;
      m_last_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      neg_q       <= neg_d;
      pend_q      <= pend_d;
      pend_last_q <= pend_last_d;
      idx_q       <= idx_d;
      m_valid_q   <= m_valid_d;
      m_data_q    <= m_data_d;
      m_last_q    <= m_last_d;
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tlast_o  = m_last_q;

  a_done_in_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    conv_res.done |-> state_q == S_CONV)
    else $error("conversion finished outside of the conversion phase");

  a_pend_slot_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> !m_valid_q)
    else $error("RAM read returned while the output register is occupied");

  a_idle_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !pend_q && !neg_q)
    else $error("ready while characters of the previous value are outstanding");

endmodule

`default_nettype wire

@@ test/tb_radix_ascii_formatter.sv @@
`default_nettype none

module tb_radix_ascii_formatter;
  import rfa_pkg::*;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } char_t;

  typedef struct {
    logic [2:0]  kind;
    logic [31:0] value;
    logic [5:0]  nb;
    string       text;
  } text_case_t;

  localparam int unsigned NUM_RANDOM = 360;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [39:0] s_axis_tdata_i = '0;
  logic [2:0]  s_axis_tuser_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [7:0]  m_axis_tdata_o;
  logic        m_axis_tlast_o;

  char_t       expected_chars[$];
  int unsigned mismatches = 0;
  bit          steady = 1'b0;

  // empty text: expected characters come from the predictor
  text_case_t directed_cases[] = '{
    '{KIND_UDEC, 32'd0,          6'd1,  "0"},
    '{KIND_UDEC, 32'hFFFF_FFFF,  6'd0,  "4294967295"},
    '{KIND_UDEC, 32'd9,          6'd63, "9"},
    '{KIND_UDEC, 32'd1000000000, 6'd5,  ""},
    '{KIND_SDEC, 32'd0,          6'd1,  "0"},
    '{KIND_SDEC, 32'h8000_0000,  6'd1,  "-2147483648"},
    '{KIND_SDEC, 32'h7FFF_FFFF,  6'd1,  "2147483647"},
    '{KIND_SDEC, 32'hFFFF_FFFF,  6'd1,  "-1"},
    '{KIND_SDEC, 32'hC0DE_1234,  6'h3F, ""},
    '{KIND_HEX,  32'd0,          6'd1,  "0"},
    '{KIND_HEX,  32'hFFFF_FFFF,  6'd1,  "FFFFFFFF"},
    '{KIND_HEX,  32'hDEAD_BEEF,  6'd1,  "DEADBEEF"},
    '{KIND_HEX,  32'h0000_000A,  6'd1,  "A"},
    '{KIND_OCT,  32'd0,          6'd1,  "0"},
    '{KIND_OCT,  32'hFFFF_FFFF,  6'd1,  "37777777777"},
    '{KIND_OCT,  32'd8,          6'd1,  "10"},
    '{KIND_BIN,  32'd5,          6'd0,  "1"},
    '{KIND_BIN,  32'd0,          6'd1,  "0"},
    '{KIND_BIN,  32'd6,          6'd4,  "0110"},
    '{KIND_BIN,  32'hFFFF_FFFF,  6'd32, ""},
    '{KIND_BIN,  32'h5555_AAAA,  6'd63, ""},
    '{KIND_BIN,  32'h8000_0001,  6'd33, ""},
    '{3'd5,      32'd1234,       6'd1,  "1234"},
    '{3'd6,      32'd0,          6'd1,  "0"},
    '{3'd7,      32'hFFFF_FFFF,  6'd1,  "4294967295"}
  };

  radix_ascii_formatter dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic int unsigned idle_cycles();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // text of one value, most significant character first
  task automatic predict_text(input logic [2:0] kind, input logic [31:0] value,
                              input logic [5:0] nb);
    logic [7:0]  text[$];
    logic [31:0] mag;
    logic [31:0] base;
    logic [31:0] d;
    int          n;
    if (kind == KIND_BIN) begin
      n = (nb == 0) ? 1 : (nb > BUF_DEPTH) ? BUF_DEPTH : int'(nb);
      for (int i = n - 1; i >= 0; i--) begin
        text.push_back(ASCII_ZERO + {7'd0, value[i]});
      end
    end else begin
      mag = value;
      base = (kind == KIND_HEX) ? 32'd16 : (kind == KIND_OCT) ? 32'd8 : 32'd10;
      if (kind == KIND_SDEC && value[31]) begin
        text.push_back(ASCII_MINUS);
        mag = -value;
      end
      n = text.size();
      if (mag == 0) text.push_back(ASCII_ZERO);
      while (mag != 0) begin
        d = mag % base;
        text.insert(n, (d > 9) ? ASCII_A + d[7:0] - 8'd10 : ASCII_ZERO + d[7:0]);
        mag = mag / base;
      end
    end
    foreach (text[i]) expected_chars.push_back('{text[i], i == text.size() - 1});
  endtask

  task automatic send_item(input logic [2:0] kind, input logic [31:0] value,
                           input logic [5:0] nb, input string text);
    int unsigned gap;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {2'b00, nb, value};
    s_axis_tuser_i  <= kind;
    do @(posedge clk_i); while (!s_axis_tready_o);
    if (text.len() == 0) begin
      predict_text(kind, value, nb);
    end else begin
      for (int i = 0; i < text.len(); i++) begin
        expected_chars.push_back('{text[i], i == text.len() - 1});
      end
    end
    @(negedge clk_i);
    gap = steady ? 0 : idle_cycles();
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  initial begin
    int unsigned rx_hold;
    rx_hold = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (rx_hold != 0) rx_hold--;
      else if (!steady) rx_hold = idle_cycles();
      m_axis_tready_i <= (rx_hold == 0);
    end
  end

  always @(posedge clk_i) begin
    char_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_chars.size() == 0) begin
        $error("unexpected char_code %0d last %0b", m_axis_tdata_o, m_axis_tlast_o);
        mismatches++;
      end else begin
        want = expected_chars.pop_front();
        if (m_axis_tdata_o !== want.code) begin
          $error("char_code: expected %0d, got %0d", want.code, m_axis_tdata_o);
          mismatches++;
        end
        if (m_axis_tlast_o !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, m_axis_tlast_o);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #20000000;
    $display("[radix_ascii_formatter] ERROR");
    $finish;
  end

  initial begin
    logic [2:0]  kind;
    logic [31:0] value;
    logic [5:0]  nb;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_cases[i]) begin
      send_item(directed_cases[i].kind, directed_cases[i].value,
                directed_cases[i].nb, directed_cases[i].text);
    end

    for (int n = 0; n < NUM_RANDOM; n++) begin
      steady = (n >= 100 && n < 160);
      if (n % 90 == 45) begin
        // drain everything in flight before going on
        s_axis_tvalid_i <= 1'b0;
        while (expected_chars.size() != 0) @(posedge clk_i);
        @(negedge clk_i);
      end
      kind = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                         : 3'($urandom_range(0, 4));
      case ($urandom_range(0, 5))
        0: value = $urandom_range(0, 99);
        1: value = 32'd1 << $urandom_range(0, 31);
        2: value = (32'd1 << $urandom_range(0, 31)) - 32'd1;
        3: value = -32'($urandom_range(1, 1000));
        4: value = ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        default: value = $urandom;
      endcase
      nb = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                       : 6'($urandom_range(1, 32));
      send_item(kind, value, nb, "");
    end
    s_axis_tvalid_i <= 1'b0;

    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[radix_ascii_formatter] OK");
    end else begin
      $display("[radix_ascii_formatter] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
